// ===== rtl/tpd_pkg.sv =====
// ----------------------------------------------------------------------------
// tpd_pkg: shared types and constants for the tree path distance block
// Holds the fixed field widths, the action and status codes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package tpd_pkg;

    localparam int ACTION_W = 2;
    localparam int NODE_W   = 10;
    localparam int EDGE_W   = 32;
    localparam int DIST_W   = 43;
    localparam int STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_START = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_QUERY = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_QA,
        S_QB,
        S_CA,
        S_CB,
        S_WALK,
        S_LOAD
    } t_state;

endpackage

// ===== rtl/tpd_ram.sv =====
// ----------------------------------------------------------------------------
// tpd_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, with the read data registered.
// ----------------------------------------------------------------------------
module tpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tree_path_distance.sv =====
// ----------------------------------------------------------------------------
// tree_path_distance: weighted path length in a rooted tree
// Keeps parent, depth and edge length per node in one RAM and answers
// distance queries by climbing parent pointers and adding up edge lengths.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+-------------------------
//   in       | input     | i_in_valid / o_in_stall  | action, parent_node,
//            |           |                          | edge_length, node_a/b
//   out      | output    | o_out_valid / i_out_stall| distance, new_node, status
//
// A start, an unused action or a rejected item goes straight to the load step,
// an add passes through the RAM write step first, and a query reads both nodes
// and then climbs until they meet. Each climb step is one RAM read and one add.
// The input is stalled from the cycle after a beat until its result is loaded
// into the output register; a result waits there while the output is stalled.
// Reset leaves the tree holding the root alone; no RAM clearing pass is needed.
// ----------------------------------------------------------------------------
module tree_path_distance
    import tpd_pkg::*;
#(
    parameter int MAX_NODES   = 1024,
    parameter int LENGTH_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [NODE_W-1:0]   i_parent_node,
    input  logic [EDGE_W-1:0]   i_edge_length,
    input  logic [NODE_W-1:0]   i_node_a,
    input  logic [NODE_W-1:0]   i_node_b,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [DIST_W-1:0]   o_distance,
    output logic [NODE_W-1:0]   o_new_node,
    output logic [STATUS_W-1:0] o_status
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int DW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int LB = LENGTH_BITS;
    localparam int WW = NODE_W + DW + LB;
    localparam int KW = CW + NODE_W;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [NODE_W-1:0]  r_node_a, n_node_a, r_node_b, n_node_b;
    logic [NODE_W-1:0]  r_par_a, n_par_a, r_par_b, n_par_b;
    logic [DW-1:0]      r_dep_a, n_dep_a, r_dep_b, n_dep_b;
    logic [LB-1:0]      r_len_a, n_len_a, r_len_b, n_len_b;
    logic [DIST_W-1:0]  r_sum, n_sum;
    logic [NODE_W-1:0]  r_new_node, n_new_node;
    t_status            r_status, n_status;
    logic               r_rd_root;
    logic               r_out_valid;
    logic [DIST_W-1:0]  r_distance;
    logic [NODE_W-1:0]  r_new_node_o;
    t_status            r_status_o;

    logic               in_acc;
    logic               out_load;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [WW-1:0]      ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [WW-1:0]      ram_q;
    logic [NODE_W-1:0]  rd_par;
    logic [DW-1:0]      rd_dep;
    logic [LB-1:0]      rd_len;
    logic               full;
    logic               par_ok, a_ok, b_ok;

    tpd_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_NODES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // The root entry is never stored; a read of node zero returns zeros.
    assign rd_par = r_rd_root ? '0 : ram_q[WW-1 -: NODE_W];
    assign rd_dep = r_rd_root ? '0 : ram_q[LB +: DW];
    assign rd_len = r_rd_root ? '0 : ram_q[LB-1:0];

    assign in_acc = i_in_valid && (r_state == S_IDLE);
    assign full   = (r_count == CW'(MAX_NODES));
    assign par_ok = KW'(i_parent_node) < KW'(r_count);
    assign a_ok   = KW'(i_node_a) < KW'(r_count);
    assign b_ok   = KW'(i_node_b) < KW'(r_count);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_node_a   = r_node_a;
        n_node_b   = r_node_b;
        n_par_a    = r_par_a;
        n_par_b    = r_par_b;
        n_dep_a    = r_dep_a;
        n_dep_b    = r_dep_b;
        n_len_a    = r_len_a;
        n_len_b    = r_len_b;
        n_sum      = r_sum;
        n_new_node = r_new_node;
        n_status   = r_status;
        out_load   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = AW'(r_count);
        ram_wdata  = {r_node_a, rd_dep + DW'(1), r_len_a};
        ram_raddr  = AW'(r_node_a);
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_sum      = '0;
                    n_new_node = '0;
                    n_status   = ST_OK;
                    n_state    = S_LOAD;
                    case (t_action'(i_action))
                        ACT_START: begin
                            n_count = CW'(1);
                        end
                        ACT_ADD: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else if (!par_ok) begin
                                n_status = ST_ABSENT;
                            end else begin
                                n_node_a  = i_parent_node;
                                n_len_a   = LB'(i_edge_length);
                                ram_raddr = AW'(i_parent_node);
                                n_state   = S_ADD;
                            end
                        end
                        ACT_QUERY: begin
                            if (!a_ok || !b_ok) begin
                                n_status = ST_ABSENT;
                            end else begin
                                n_node_a  = i_node_a;
                                n_node_b  = i_node_b;
                                ram_raddr = AW'(i_node_a);
                                n_state   = S_QA;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD: begin
                ram_we     = 1'b1;
                n_count    = r_count + CW'(1);
                n_new_node = NODE_W'(r_count);
                n_state    = S_LOAD;
            end
            S_QA, S_CA: begin
                n_par_a = rd_par;
                n_dep_a = rd_dep;
                n_len_a = rd_len;
                if (r_state == S_QA) begin
                    ram_raddr = AW'(r_node_b);
                    n_state   = S_QB;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_QB, S_CB: begin
                n_par_b = rd_par;
                n_dep_b = rd_dep;
                n_len_b = rd_len;
                n_state = S_WALK;
            end
            S_WALK: begin
                if (r_node_a == r_node_b) begin
                    n_state = S_LOAD;
                end else if (r_dep_a >= r_dep_b) begin
                    n_sum     = r_sum + DIST_W'(r_len_a);
                    n_node_a  = r_par_a;
                    ram_raddr = AW'(r_par_a);
                    n_state   = S_CA;
                end else begin
                    n_sum     = r_sum + DIST_W'(r_len_b);
                    n_node_b  = r_par_b;
                    ram_raddr = AW'(r_par_b);
                    n_state   = S_CB;
                end
            end
            S_LOAD: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= CW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_node_a   <= n_node_a;
        r_node_b   <= n_node_b;
        r_par_a    <= n_par_a;
        r_par_b    <= n_par_b;
        r_dep_a    <= n_dep_a;
        r_dep_b    <= n_dep_b;
        r_len_a    <= n_len_a;
        r_len_b    <= n_len_b;
        r_sum      <= n_sum;
        r_new_node <= n_new_node;
        r_status   <= n_status;
        r_rd_root  <= (ram_raddr == '0);
        if (out_load) begin
            r_distance   <= r_sum;
            r_new_node_o <= r_new_node;
            r_status_o   <= r_status;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_distance  = r_distance;
    assign o_new_node  = r_new_node_o;
    assign o_status    = r_status_o;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(1)) && (r_count <= CW'(MAX_NODES)))
        else $error("Node count left its range.");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_count < CW'(MAX_NODES)))
        else $error("Table write with no free entry.");

    a_meet_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WALK) && (r_node_a == r_node_b)) |-> (r_dep_a == r_dep_b))
        else $error("Climb met at a node with two different depths.");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("Input not stalled after an accepted beat.");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_LOAD))
        else $error("Result raised outside the load step.");

endmodule
